// ===== hw/rtl/fhfe_pkg.sv =====
// shared types, codes, the record push helper and the ethertype kind helper for the header field extractor
`timescale 1ns / 1ps
package fhfe_pkg;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned MAX_REC = 3;

  localparam logic [2:0] LY_ETH  = 3'd0;
  localparam logic [2:0] LY_IPV4 = 3'd1;
  localparam logic [2:0] LY_IPV6 = 3'd2;
  localparam logic [2:0] LY_TCP  = 3'd3;
  localparam logic [2:0] LY_UDP  = 3'd4;
  localparam logic [2:0] LY_ICMP = 3'd5;
  localparam logic [2:0] LY_END  = 3'd6;

  localparam logic [1:0] NK_NONE  = 2'd0;
  localparam logic [1:0] NK_IPV4  = 2'd1;
  localparam logic [1:0] NK_IPV6  = 2'd2;
  localparam logic [1:0] NK_OTHER = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_SHORT_TAG = 3'd2;
  localparam logic [2:0] ST_SHORT_L3  = 3'd3;
  localparam logic [2:0] ST_IHL       = 3'd4;
  localparam logic [2:0] ST_UDP_LEN   = 3'd5;

  localparam logic [15:0] ET_VLAN = 16'h8100;
  localparam logic [15:0] ET_QINQ = 16'h88A8;
  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_ARP  = 16'h0806;
  localparam logic [15:0] ET_IPV6 = 16'h86DD;

  localparam logic [7:0] PR_ICMP = 8'd1;
  localparam logic [7:0] PR_TCP  = 8'd6;
  localparam logic [7:0] PR_UDP  = 8'd17;

  typedef struct packed {
    logic [2:0]  layer;
    logic [3:0]  ordinal;
    logic [63:0] value;
  } rec_t;

  typedef struct packed {
    rec_t [MAX_REC-1:0] recs;
    logic [1:0]         num;
  } rec_set_t;

  function automatic rec_set_t push(rec_set_t s, logic [2:0] ly, logic [3:0] ord,
                                    logic [63:0] val);
    rec_set_t o;
    o = s;
    if (s.num < 2'(MAX_REC)) begin
      o.recs[s.num] = '{layer: ly, ordinal: ord, value: val};
      o.num         = s.num + 2'd1;
    end
    return o;
  endfunction

  function automatic logic [1:0] kind_of(logic [15:0] et);
    if (et == ET_IPV4) return NK_IPV4;
    if (et == ET_IPV6) return NK_IPV6;
    return NK_OTHER;
  endfunction

endpackage

// ===== hw/rtl/frame_header_field_extractor.sv =====
// top level: byte-serial ethernet/ip/transport header field extractor
// latency: records of a byte appear the cycle after the byte is accepted
// throughput: one byte per cycle while the output is not stalled and each byte
//   yields at most one record; a byte with more holds the input until they drain
// reset: asynchronous active low, clears parse state and the output record count
`timescale 1ns / 1ps
module frame_header_field_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  layer_o,
  output logic [3:0]  ordinal_o,
  output logic [63:0] field_value_o,
  output logic        run_last_o
);
  import fhfe_pkg::*;

  rec_set_t res;
  logic     can_load, take_in;

  assign in_stall_o = !can_load;
  assign take_in    = in_valid_i && can_load;

  fhfe_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take_in),
    .data_byte_i  (data_byte_i),
    .frame_last_i (frame_last_i),
    .res_o        (res)
  );

  fhfe_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take_in),
    .res_i         (res),
    .out_stall_i   (out_stall_i),
    .can_load_o    (can_load),
    .out_valid_o   (out_valid_o),
    .layer_o       (layer_o),
    .ordinal_o     (ordinal_o),
    .field_value_o (field_value_o),
    .run_last_o    (run_last_o)
  );

endmodule

// ===== hw/rtl/fhfe_parser.sv =====
// parse state registers and per-byte record generation
`timescale 1ns / 1ps
module fhfe_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        data_byte_i,
  input  logic              frame_last_i,
  output fhfe_pkg::rec_set_t res_o
);
  import fhfe_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [63:0]      acc_q, acc_d;
  logic             tag_q, tag_d;
  logic [1:0]       nk_q, nk_d;
  logic [3:0]       ihl_q, ihl_d;
  logic [15:0]      tot_q, tot_d;
  logic [7:0]       proto_q, proto_d;
  logic [2:0]       st_q, st_d;

  logic [POS_W-1:0] l3, l3n, r, t;
  logic [POS_W:0]   n;
  logic [15:0]      w16;
  logic             udp_short;
  logic [2:0]       st_end;
  rec_set_t         s;

  always_comb begin
    s         = '0;
    acc_d     = {acc_q[55:0], data_byte_i};
    tag_d     = tag_q;
    nk_d      = nk_q;
    ihl_d     = ihl_q;
    tot_d     = tot_q;
    proto_d   = proto_q;
    st_d      = st_q;
    st_end    = ST_OK;
    w16       = acc_d[15:0];
    l3        = tag_q ? POS_W'(18) : POS_W'(14);
    r         = pos_q - l3;
    t         = r - POS_W'({ihl_q, 2'b00});
    udp_short = {1'b0, tot_q} < ({11'd0, ihl_q, 2'b00} + 17'd8);

    if (pos_q == POS_W'(5))  s = push(s, LY_ETH, 4'd0, {16'd0, acc_d[47:0]});
    if (pos_q == POS_W'(11)) s = push(s, LY_ETH, 4'd1, {16'd0, acc_d[47:0]});

    if (pos_q == POS_W'(13)) begin
      if (w16 == ET_VLAN || w16 == ET_QINQ) begin
        tag_d = 1'b1;
      end else begin
        s    = push(s, LY_ETH, 4'd2, {48'd0, w16});
        s    = push(s, LY_ETH, 4'd3, 64'd0);
        nk_d = kind_of(w16);
      end
    end else if (pos_q == POS_W'(17) && tag_q && nk_q == NK_NONE) begin
      s    = push(s, LY_ETH, 4'd2, {48'd0, w16});
      s    = push(s, LY_ETH, 4'd3, 64'd1);
      nk_d = kind_of(w16);
    end else if (nk_q == NK_IPV4 && pos_q >= l3) begin
      case (r)
        POS_W'(0): begin
          ihl_d = data_byte_i[3:0];
          s = push(s, LY_IPV4, 4'd0, {60'd0, data_byte_i[7:4]});
          s = push(s, LY_IPV4, 4'd1, {60'd0, data_byte_i[3:0]});
          if (data_byte_i[3:0] < 4'd5) st_d = ST_IHL;
        end
        POS_W'(1): begin
          s = push(s, LY_IPV4, 4'd2, {58'd0, data_byte_i[7:2]});
          s = push(s, LY_IPV4, 4'd3, {62'd0, data_byte_i[1:0]});
        end
        POS_W'(3): begin
          tot_d = w16;
          s = push(s, LY_IPV4, 4'd4, {48'd0, w16});
        end
        POS_W'(5):  s = push(s, LY_IPV4, 4'd5, {48'd0, w16});
        POS_W'(6):  s = push(s, LY_IPV4, 4'd6, {61'd0, data_byte_i[7:5]});
        POS_W'(7):  s = push(s, LY_IPV4, 4'd7, {51'd0, acc_d[12:0]});
        POS_W'(8):  s = push(s, LY_IPV4, 4'd8, {56'd0, data_byte_i});
        POS_W'(9): begin
          proto_d = data_byte_i;
          s = push(s, LY_IPV4, 4'd9, {56'd0, data_byte_i});
        end
        POS_W'(11): s = push(s, LY_IPV4, 4'd10, {48'd0, w16});
        POS_W'(15): s = push(s, LY_IPV4, 4'd11, {32'd0, acc_d[31:0]});
        POS_W'(19): begin
          s = push(s, LY_IPV4, 4'd12, {32'd0, acc_d[31:0]});
          if (proto_q == PR_UDP && ihl_q >= 4'd5 && udp_short && st_q == ST_OK)
            st_d = ST_UDP_LEN;
        end
        default: ;
      endcase
      // transport header sits after the options
      if (ihl_q >= 4'd5 && r >= POS_W'({ihl_q, 2'b00})) begin
        if (proto_q == PR_TCP) begin
          case (t)
            POS_W'(1):  s = push(s, LY_TCP, 4'd0, {48'd0, w16});
            POS_W'(3):  s = push(s, LY_TCP, 4'd1, {48'd0, w16});
            POS_W'(7):  s = push(s, LY_TCP, 4'd2, {32'd0, acc_d[31:0]});
            POS_W'(11): s = push(s, LY_TCP, 4'd3, {32'd0, acc_d[31:0]});
            POS_W'(12): s = push(s, LY_TCP, 4'd4, {60'd0, data_byte_i[7:4]});
            POS_W'(13): s = push(s, LY_TCP, 4'd5, {56'd0, data_byte_i});
            POS_W'(15): s = push(s, LY_TCP, 4'd6, {48'd0, w16});
            POS_W'(17): s = push(s, LY_TCP, 4'd7, {48'd0, w16});
            POS_W'(19): s = push(s, LY_TCP, 4'd8, {48'd0, w16});
            default: ;
          endcase
        end else if (proto_q == PR_UDP) begin
          if (!udp_short) begin
            case (t)
              POS_W'(1): s = push(s, LY_UDP, 4'd0, {48'd0, w16});
              POS_W'(3): s = push(s, LY_UDP, 4'd1, {48'd0, w16});
              POS_W'(5): s = push(s, LY_UDP, 4'd2, {48'd0, w16});
              POS_W'(7): s = push(s, LY_UDP, 4'd3, {48'd0, w16});
              default: ;
            endcase
          end
        end else if (proto_q == PR_ICMP) begin
          case (t)
            POS_W'(0): s = push(s, LY_ICMP, 4'd0, {56'd0, data_byte_i});
            POS_W'(1): s = push(s, LY_ICMP, 4'd1, {56'd0, data_byte_i});
            POS_W'(3): s = push(s, LY_ICMP, 4'd2, {48'd0, w16});
            POS_W'(5): s = push(s, LY_ICMP, 4'd3, {48'd0, w16});
            POS_W'(7): s = push(s, LY_ICMP, 4'd4, {48'd0, w16});
            default: ;
          endcase
        end
      end
    end else if (nk_q == NK_IPV6 && pos_q >= l3) begin
      case (r)
        POS_W'(0):  s = push(s, LY_IPV6, 4'd0, {60'd0, data_byte_i[7:4]});
        POS_W'(1):  s = push(s, LY_IPV6, 4'd1, {56'd0, acc_d[11:4]});
        POS_W'(3):  s = push(s, LY_IPV6, 4'd2, {44'd0, acc_d[19:0]});
        POS_W'(5):  s = push(s, LY_IPV6, 4'd3, {48'd0, w16});
        POS_W'(6):  s = push(s, LY_IPV6, 4'd4, {56'd0, data_byte_i});
        POS_W'(7):  s = push(s, LY_IPV6, 4'd5, {56'd0, data_byte_i});
        POS_W'(15): s = push(s, LY_IPV6, 4'd6, acc_d);
        POS_W'(23): s = push(s, LY_IPV6, 4'd7, acc_d);
        POS_W'(31): s = push(s, LY_IPV6, 4'd8, acc_d);
        POS_W'(39): s = push(s, LY_IPV6, 4'd9, acc_d);
        default: ;
      endcase
    end

    pos_d = (pos_q != {POS_W{1'b1}}) ? pos_q + POS_W'(1) : pos_q;

    n   = {1'b0, pos_q} + (POS_W+1)'(1);
    l3n = tag_d ? POS_W'(18) : POS_W'(14);
    if (frame_last_i) begin
      if (n < (POS_W+1)'(14)) st_end = ST_SHORT;
      else if (tag_d && n < (POS_W+1)'(18)) st_end = ST_SHORT_TAG;
      else if ((nk_d == NK_IPV4 && n < {1'b0, l3n} + (POS_W+1)'(20)) ||
               (nk_d == NK_IPV6 && n < {1'b0, l3n} + (POS_W+1)'(40)))
        st_end = ST_SHORT_L3;
      else st_end = st_d;
      s = push(s, LY_END, 4'd0, {61'd0, st_end});
      // back to the start of a frame
      pos_d   = '0;
      acc_d   = '0;
      tag_d   = 1'b0;
      nk_d    = NK_NONE;
      ihl_d   = '0;
      tot_d   = '0;
      proto_d = '0;
      st_d    = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      acc_q   <= '0;
      tag_q   <= 1'b0;
      nk_q    <= NK_NONE;
      ihl_q   <= '0;
      tot_q   <= '0;
      proto_q <= '0;
      st_q    <= ST_OK;
    end else if (take_i) begin
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      tag_q   <= tag_d;
      nk_q    <= nk_d;
      ihl_q   <= ihl_d;
      tot_q   <= tot_d;
      proto_q <= proto_d;
      st_q    <= st_d;
    end
  end

  assign res_o = s;

endmodule

// ===== hw/rtl/fhfe_outbuf.sv =====
// result register holding the records of one byte, drained one per request
`timescale 1ns / 1ps
module fhfe_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  fhfe_pkg::rec_set_t res_i,
  input  logic               out_stall_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  output logic [2:0]         layer_o,
  output logic [3:0]         ordinal_o,
  output logic [63:0]        field_value_o,
  output logic               run_last_o
);
  import fhfe_pkg::*;

  rec_t [MAX_REC-1:0] recs_q;
  logic [1:0]         rd_q, rem_q;
  logic               take;
  rec_t               cur;

  assign take        = (rem_q != 2'd0) && !out_stall_i;
  assign can_load_o  = (rem_q == 2'd0) || (rem_q == 2'd1 && !out_stall_i);
  assign out_valid_o = rem_q != 2'd0;
  assign cur         = recs_q[rd_q];
  assign layer_o       = cur.layer;
  assign ordinal_o     = cur.ordinal;
  assign field_value_o = cur.value;
  assign run_last_o    = rem_q == 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      rem_q <= '0;
    end else if (load_i) begin
      rd_q  <= '0;
      rem_q <= res_i.num;
    end else if (take) begin
      rd_q  <= rd_q + 2'd1;
      rem_q <= rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) recs_q <= res_i.recs;
  end

endmodule
